FILE: hw/rtl/qshtc_pkg.sv
package qshtc_pkg;

  localparam int unsigned Depth = 1024;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CountW = AddrW + 1;
  localparam int unsigned DataW = 32;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [DataW-1:0] data_t;

  // Candidate bits
  localparam logic [2:0] CandQueue = 3'b001;
  localparam logic [2:0] CandHeap = 3'b010;
  localparam logic [2:0] CandStack = 3'b100;
  localparam logic [2:0] CandAll = 3'b111;

  // Verdict codes
  localparam logic [2:0] VerdictImpossible = 3'd0;
  localparam logic [2:0] VerdictNotSure = 3'd1;
  localparam logic [2:0] VerdictQueue = 3'd2;
  localparam logic [2:0] VerdictHeap = 3'd3;
  localparam logic [2:0] VerdictStack = 3'd4;

  // Operation codes
  localparam logic ModePush = 1'b0;
  localparam logic ModePop = 1'b1;

  function automatic logic [2:0] verdict_of(input logic [2:0] c);
    logic [2:0] v;
    unique case (c)
      3'b000: v = VerdictImpossible;
      CandQueue: v = VerdictQueue;
      CandHeap: v = VerdictHeap;
      CandStack: v = VerdictStack;
      default: v = VerdictNotSure;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/qshtc_in_if.sv
interface qshtc_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic signed [31:0] value;
  logic start_req;
  modport source(output valid, mode, value, start_req, input ready);
  modport sink(input valid, mode, value, start_req, output ready);
endinterface

FILE: hw/rtl/qshtc_out_if.sv
interface qshtc_out_if;
  logic valid;
  logic ready;
  logic [2:0] verdict;
  logic overflow;
  modport source(output valid, verdict, overflow, input ready);
  modport sink(input valid, verdict, overflow, output ready);
endinterface

FILE: hw/rtl/queue_stack_heap_trace_classifier_unit.sv
// Channel | Dir | Payload                          | Handshake
// in_ch   | in  | mode, value[31:0] s, start_req   | valid/ready
// out_ch  | out | verdict[2:0], overflow           | valid/ready
//
// One transaction at a time; the heap memory port sets the cycle count.
// A push writes the queue and stack memories, then lifts the value up the
// heap while its parent is smaller. A pop checks the three fronts, then reads
// the last heap element and sinks it from the root while a child is larger. A
// push when full or a pop on empty goes straight to the result. Reset is
// synchronous; no memory is cleared. A stalled out_ch holds only the waiting
// result; the next transaction is taken and worked on up to its own result.
module queue_stack_heap_trace_classifier_unit (
  input logic clk,
  input logic rst_n,
  qshtc_in_if.sink    in_ch,
  qshtc_out_if.source out_ch
);
  localparam int unsigned AW = qshtc_pkg::AddrW;

  typedef enum logic [3:0] {
    S_IDLE, S_POPRD, S_POPCMP, S_SIFTRD, S_SIFTCMP, S_SIFTRT,
    S_UPRD, S_UPCMP, S_DONE
  } state_t;

  state_t state_r;
  qshtc_pkg::addr_t head_r, tail_r;
  qshtc_pkg::count_t cnt_r;
  logic [2:0] cand_r;
  logic ovf_r;
  qshtc_pkg::data_t val_r;
  qshtc_pkg::data_t cur_r;      // value travelling in the heap
  qshtc_pkg::count_t idx_r;     // heap position of cur_r
  qshtc_pkg::data_t lval_r;     // left child value
  logic out_valid_r;
  logic [2:0] verdict_r;
  logic out_ovf_r;

  // Memory ports
  logic f_we, l_we, h_we;
  qshtc_pkg::addr_t f_wa, l_wa, h_wa, f_ra, l_ra, h_ra;
  qshtc_pkg::data_t f_wd, l_wd, h_wd, f_rd, l_rd, h_rd;

  qshtc_ram #(.Width(qshtc_pkg::DataW), .Depth(qshtc_pkg::Depth)) u_fifo (
    .clk, .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));
  qshtc_ram #(.Width(qshtc_pkg::DataW), .Depth(qshtc_pkg::Depth)) u_lifo (
    .clk, .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
  qshtc_ram #(.Width(qshtc_pkg::DataW), .Depth(qshtc_pkg::Depth)) u_heap (
    .clk, .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));

  function automatic logic slt(input qshtc_pkg::data_t a, input qshtc_pkg::data_t b);
    return $signed(a) < $signed(b);
  endfunction

  logic in_fire, out_free, done_fire;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign done_fire = (state_r == S_DONE) && out_free;
  assign out_ch.valid = out_valid_r;
  assign out_ch.verdict = verdict_r;
  assign out_ch.overflow = out_ovf_r;

  // Effective state after an optional start
  qshtc_pkg::count_t cnt_e;
  qshtc_pkg::addr_t head_e, tail_e;
  logic [2:0] cand_e;
  logic ovf_e, full_e;
  assign cnt_e = in_ch.start_req ? '0 : cnt_r;
  assign head_e = in_ch.start_req ? '0 : head_r;
  assign tail_e = in_ch.start_req ? '0 : tail_r;
  assign cand_e = in_ch.start_req ? qshtc_pkg::CandAll : cand_r;
  assign ovf_e = in_ch.start_req ? 1'b0 : ovf_r;
  assign full_e = cnt_e >= qshtc_pkg::count_t'(qshtc_pkg::Depth);

  // Heap navigation
  qshtc_pkg::count_t lidx, ridx, pidx;
  assign lidx = {idx_r[AW-1:0], 1'b1};
  assign ridx = lidx + qshtc_pkg::count_t'(1);
  assign pidx = (idx_r - qshtc_pkg::count_t'(1)) >> 1;
  logic l_ok, r_ok;
  assign l_ok = lidx < cnt_r;
  assign r_ok = l_ok && (ridx < cnt_r);

  // Heap comparisons against the word just read
  logic cur_lt_rd, rd_lt_cur, left_big, right_big;
  qshtc_pkg::data_t big_v;
  assign cur_lt_rd = slt(cur_r, h_rd);
  assign rd_lt_cur = slt(h_rd, cur_r);
  assign left_big = slt(cur_r, lval_r);
  assign big_v = left_big ? lval_r : cur_r;
  assign right_big = slt(big_v, h_rd);

  // Drop each candidate whose front, top or maximum disagrees
  logic [2:0] cand_nxt;
  always_comb begin
    cand_nxt = cand_r;
    if (f_rd != val_r) cand_nxt = cand_nxt & ~qshtc_pkg::CandQueue;
    if (h_rd != val_r) cand_nxt = cand_nxt & ~qshtc_pkg::CandHeap;
    if (l_rd != val_r) cand_nxt = cand_nxt & ~qshtc_pkg::CandStack;
  end

  // Memory port control
  always_comb begin
    f_we = 1'b0; l_we = 1'b0; h_we = 1'b0;
    f_wa = tail_e; l_wa = cnt_e[AW-1:0]; h_wa = idx_r[AW-1:0];
    f_wd = in_ch.value; l_wd = in_ch.value; h_wd = cur_r;
    f_ra = head_e; l_ra = cnt_e[AW-1:0] - qshtc_pkg::addr_t'(1); h_ra = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_ch.mode == qshtc_pkg::ModePush && !full_e) begin
          f_we = 1'b1;
          l_we = 1'b1;
        end
      end
      // Fetch the last heap element
      S_POPRD: h_ra = cnt_r[AW-1:0] - qshtc_pkg::addr_t'(1);
      S_POPCMP: ;
      S_SIFTRD: begin
        if (l_ok) h_ra = lidx[AW-1:0];
        else h_we = 1'b1;
      end
      S_SIFTCMP: begin
        if (r_ok) begin
          h_ra = ridx[AW-1:0];
        end else begin
          h_we = 1'b1;
          if (cur_lt_rd) h_wd = h_rd;
        end
      end
      S_SIFTRT: begin
        h_we = 1'b1;
        if (right_big) h_wd = h_rd;
        else if (left_big) h_wd = lval_r;
      end
      S_UPRD: begin
        if (idx_r == '0) h_we = 1'b1;
        else h_ra = pidx[AW-1:0];
      end
      S_UPCMP: begin
        h_we = 1'b1;
        if (rd_lt_cur) h_wd = h_rd;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r <= '0; tail_r <= '0; cnt_r <= '0;
      cand_r <= qshtc_pkg::CandAll; ovf_r <= 1'b0;
      out_valid_r <= 1'b0;
      verdict_r <= qshtc_pkg::VerdictImpossible;
      out_ovf_r <= 1'b0;
    end else begin
      // Load the result register, or drop a consumed result
      if (done_fire) begin
        out_valid_r <= 1'b1;
        verdict_r <= qshtc_pkg::verdict_of(cand_r);
        out_ovf_r <= ovf_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: if (in_fire) begin
          val_r <= in_ch.value;
          head_r <= head_e;
          if (in_ch.mode == qshtc_pkg::ModePush) begin
            cand_r <= cand_e;
            if (full_e) begin
              tail_r <= tail_e; cnt_r <= cnt_e;
              ovf_r <= 1'b1;
              state_r <= S_DONE;
            end else begin
              tail_r <= tail_e + qshtc_pkg::addr_t'(1);
              cnt_r <= cnt_e + qshtc_pkg::count_t'(1);
              ovf_r <= ovf_e;
              cur_r <= in_ch.value;
              idx_r <= cnt_e;
              state_r <= S_UPRD;
            end
          end else begin
            tail_r <= tail_e; cnt_r <= cnt_e; ovf_r <= ovf_e;
            if (cnt_e == '0) begin
              cand_r <= '0;
              state_r <= S_DONE;
            end else begin
              cand_r <= cand_e;
              state_r <= S_POPRD;
            end
          end
        end
        S_POPRD: begin
          // fifo/lifo/heap[0] data valid now
          cand_r <= cand_nxt;
          head_r <= head_r + qshtc_pkg::addr_t'(1);
          cnt_r <= cnt_r - qshtc_pkg::count_t'(1);
          state_r <= S_POPCMP;
        end
        S_POPCMP: begin
          // last element read; sink it from the root
          cur_r <= h_rd;
          idx_r <= '0;
          state_r <= S_SIFTRD;
        end
        S_SIFTRD: state_r <= l_ok ? S_SIFTCMP : S_DONE;
        S_SIFTCMP: begin
          lval_r <= h_rd;
          if (r_ok) begin
            state_r <= S_SIFTRT;
          end else if (cur_lt_rd) begin
            idx_r <= lidx;
            state_r <= S_SIFTRD;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_SIFTRT: begin
          if (right_big) begin
            idx_r <= ridx;
            state_r <= S_SIFTRD;
          end else if (left_big) begin
            idx_r <= lidx;
            state_r <= S_SIFTRD;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_UPRD: begin
          if (idx_r == '0) state_r <= S_DONE;
          else state_r <= S_UPCMP;
        end
        S_UPCMP: begin
          if (rd_lt_cur) begin
            idx_r <= pidx;
            state_r <= S_UPRD;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: if (out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: hw/rtl/qshtc_ram.sv
module qshtc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: sim/qshtc_trace_checker.sv
module qshtc_trace_checker (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  logic in_mode,
  input  logic [31:0] in_value,
  input  logic in_start_req,
  input  logic out_valid,
  input  logic out_ready,
  input  logic [2:0] out_verdict,
  input  logic out_overflow,
  output int unsigned fail_count,
  output int unsigned verdicts_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] verdict;
    logic       overflow;
  } verdict_t;

  // Shadow copies of the three structures
  logic signed [31:0] queue_q[$];
  logic signed [31:0] stack_q[$];
  logic signed [31:0] heap_mem[qshtc_pkg::Depth];
  int unsigned heap_cnt;
  logic [2:0] cand;
  logic ovf;
  verdict_t verdict_q[$];

  function automatic logic [2:0] classify(input logic [2:0] c);
    case (c)
      3'b000:              return qshtc_pkg::VerdictImpossible;
      qshtc_pkg::CandQueue: return qshtc_pkg::VerdictQueue;
      qshtc_pkg::CandHeap:  return qshtc_pkg::VerdictHeap;
      qshtc_pkg::CandStack: return qshtc_pkg::VerdictStack;
      default:             return qshtc_pkg::VerdictNotSure;
    endcase
  endfunction

  // Advance the shadow state by one transaction and queue its verdict
  task automatic apply_op(input logic mode, input logic signed [31:0] v, input logic start);
    int unsigned i;
    int unsigned up;
    int unsigned l;
    int unsigned big;
    logic signed [31:0] t;
    verdict_t e;
    if (start) begin
      queue_q.delete();
      stack_q.delete();
      heap_cnt = 0;
      cand = qshtc_pkg::CandAll;
      ovf = 1'b0;
    end
    if (mode == qshtc_pkg::ModePush) begin
      if (heap_cnt >= qshtc_pkg::Depth) begin
        ovf = 1'b1;
      end else begin
        queue_q.push_back(v);
        stack_q.push_back(v);
        i = heap_cnt;
        heap_mem[i] = v;
        while (i > 0) begin
          up = (i - 1) / 2;
          if (!(heap_mem[up] < heap_mem[i])) break;
          t = heap_mem[up]; heap_mem[up] = heap_mem[i]; heap_mem[i] = t;
          i = up;
        end
        heap_cnt++;
      end
    end else if (heap_cnt == 0) begin
      cand = 3'b000;
    end else begin
      if (queue_q[0] != v) cand &= ~qshtc_pkg::CandQueue;
      if (heap_mem[0] != v) cand &= ~qshtc_pkg::CandHeap;
      if (stack_q[$] != v) cand &= ~qshtc_pkg::CandStack;
      void'(queue_q.pop_front());
      void'(stack_q.pop_back());
      heap_cnt--;
      heap_mem[0] = heap_mem[heap_cnt];
      i = 0;
      forever begin
        l = 2 * i + 1;
        big = i;
        if (l < heap_cnt && heap_mem[big] < heap_mem[l]) big = l;
        if (l + 1 < heap_cnt && heap_mem[big] < heap_mem[l + 1]) big = l + 1;
        if (big == i) break;
        t = heap_mem[big]; heap_mem[big] = heap_mem[i]; heap_mem[i] = t;
        i = big;
      end
    end
    e.verdict = classify(cand);
    e.overflow = ovf;
    verdict_q.push_back(e);
  endtask

  // Predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst_n) begin
      queue_q.delete();
      stack_q.delete();
      verdict_q.delete();
      heap_cnt = 0;
      cand = qshtc_pkg::CandAll;
      ovf = 1'b0;
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result verdict=%0d overflow=%0b",
                   $time, out_verdict, out_overflow);
          fail_count++;
        end else begin
          exp_v = verdict_q.pop_front();
          if (exp_v.verdict !== out_verdict || exp_v.overflow !== out_overflow) begin
            $display("%0t: mismatch expected verdict=%0d overflow=%0b,",
                     $time, exp_v.verdict, exp_v.overflow,
                     " got verdict=%0d overflow=%0b", out_verdict, out_overflow);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) apply_op(in_mode, in_value, in_start_req);
    end
    verdicts_pending = verdict_q.size();
  end
endmodule

FILE: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int unsigned fail_count;
  int unsigned verdicts_pending;
  int unsigned sent;
  bit calm;

  qshtc_in_if  in_ch();
  qshtc_out_if out_ch();

  always #1 clk = ~clk;

  queue_stack_heap_trace_classifier_unit u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  qshtc_trace_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_mode(in_ch.mode),
    .in_value(in_ch.value), .in_start_req(in_ch.start_req),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_verdict(out_ch.verdict), .out_overflow(out_ch.overflow),
    .fail_count(fail_count), .verdicts_pending(verdicts_pending)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = qshtc_pkg::ModePush;
    in_ch.value = '0;
    in_ch.start_req = 1'b0;
    out_ch.ready = 1'b0;
  end

  // Sink side: random stall bursts, none late in the run
  initial begin
    int unsigned n;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        n = $urandom_range(1, 18);
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Send one transaction, with an optional idle burst first
  task automatic send_op(input logic mode, input logic [31:0] v, input logic start);
    int unsigned n;
    if (!calm && $urandom_range(0, 6) == 0) begin
      in_ch.valid <= 1'b0;
      n = $urandom_range(1, 18);
      repeat (n) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.value <= v;
    in_ch.start_req <= start;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  function automatic logic [31:0] rand_value(input int unsigned spread);
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'h7fff_fffc + $urandom_range(0, 3);
      default: return $urandom_range(0, spread);
    endcase
  endfunction

  // Trace of one kind, then pop it back in that kind's order, now and then with a bit flipped
  task automatic run_trace(input int unsigned kind, input int unsigned len);
    logic signed [31:0] vals[$];
    logic signed [31:0] pick;
    int unsigned k;
    int unsigned j;
    int unsigned best;
    for (k = 0; k < len; k++) begin
      pick = rand_value(20);
      vals.push_back(pick);
      send_op(qshtc_pkg::ModePush, pick, k == 0);
    end
    while (vals.size() > 0) begin
      if (kind == 0) pick = vals.pop_front();
      else if (kind == 1) pick = vals.pop_back();
      else begin
        best = 0;
        for (j = 1; j < vals.size(); j++) if (vals[j] > vals[best]) best = j;
        pick = vals[best];
        vals.delete(best);
      end
      if ($urandom_range(0, 15) == 0) pick = pick ^ (32'h1 << $urandom_range(0, 31));
      send_op(qshtc_pkg::ModePop, pick, 1'b0);
    end
  endtask

  initial begin
    int unsigned k;
    sent = 0;
    calm = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: pop on empty, field extremes, each kind alone
    send_op(qshtc_pkg::ModePop, 32'h0, 1'b0);
    send_op(qshtc_pkg::ModePush, 32'h8000_0000, 1'b1);
    send_op(qshtc_pkg::ModePush, 32'h7fff_ffff, 1'b0);
    send_op(qshtc_pkg::ModePush, 32'hffff_ffff, 1'b0);
    send_op(qshtc_pkg::ModePop, 32'h7fff_ffff, 1'b0);
    send_op(qshtc_pkg::ModePop, 32'hffff_ffff, 1'b0);
    send_op(qshtc_pkg::ModePop, 32'h8000_0000, 1'b0);
    send_op(qshtc_pkg::ModePop, 32'h1, 1'b0);
    send_op(qshtc_pkg::ModePop, 32'h5, 1'b1);
    send_op(qshtc_pkg::ModePush, 32'h3, 1'b1);
    send_op(qshtc_pkg::ModePop, 32'h3, 1'b0);
    run_trace(0, 4);
    run_trace(1, 4);
    run_trace(2, 4);

    // Wait for the block to drain
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);

    // Fill past capacity, pop a few back
    for (k = 0; k < qshtc_pkg::Depth + 3; k++)
      send_op(qshtc_pkg::ModePush, $urandom, k == 0);
    for (k = 0; k < 6; k++) send_op(qshtc_pkg::ModePop, $urandom, 1'b0);

    // Random traces with some noise
    while (sent < 1150) begin
      if (sent > 1100) calm = 1;
      if ($urandom_range(0, 4) == 0)
        send_op(1'($urandom_range(0, 1)), rand_value(8), $urandom_range(0, 7) == 0);
      else
        run_trace($urandom_range(0, 2), $urandom_range(1, 12));
    end
    in_ch.valid <= 1'b0;

    while (verdicts_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end
endmodule
